@@ rtl/register_vm_execute_unit_assert.svh @@
// Assertion macros shared by the execute unit RTL.
// RVM_ASSERT expects signals named clk and rst in the enclosing module; RVM_ASSERT_ALWAYS needs only clk.
`ifndef REGISTER_VM_EXECUTE_UNIT_ASSERT_SVH
`define REGISTER_VM_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RVM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVM_ASSERT(label, prop, msg)
`define RVM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/rvm_pkg.sv @@
package rvm_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int IMM_W  = 16;
  localparam int CMD_W  = 4;

  // Codes 12..15 have no member and fall to the default arm (no operation).
  typedef enum logic [CMD_W-1:0] {
    CMD_HALT  = 4'd0,
    CMD_LOAD  = 4'd1,
    CMD_STORE = 4'd2,
    CMD_INC   = 4'd3,
    CMD_DEC   = 4'd4,
    CMD_ADD   = 4'd5,
    CMD_SUB   = 4'd6,
    CMD_MUL   = 4'd7,
    CMD_DIV   = 4'd8,
    CMD_AND   = 4'd9,
    CMD_JUMP  = 4'd10,
    CMD_JZ    = 4'd11
  } cmd_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rf_wr_t;

endpackage

@@ rtl/rvm_instr_if.sv @@
interface rvm_instr_if;
  logic                        valid;
  logic                        ready;
  logic [rvm_pkg::CMD_W-1:0]   command;
  logic [rvm_pkg::IDX_W-1:0]   reg_a;
  logic [rvm_pkg::IDX_W-1:0]   reg_b;
  logic [rvm_pkg::IDX_W-1:0]   reg_c;
  logic [rvm_pkg::IMM_W-1:0]   immediate;

  modport source (
    output valid, command, reg_a, reg_b, reg_c, immediate,
    input  ready
  );
  modport sink (
    input  valid, command, reg_a, reg_b, reg_c, immediate,
    output ready
  );
endinterface

@@ rtl/rvm_result_if.sv @@
interface rvm_result_if;
  logic                             valid;
  logic                             ready;
  logic [rvm_pkg::DATA_W-1:0]       fetch_address;
  logic                             halted;
  logic                             wrote_register;
  logic [rvm_pkg::IDX_W-1:0]        written_index;
  logic signed [rvm_pkg::DATA_W-1:0] written_value;
  logic                             divide_fault;

  modport source (
    output valid, fetch_address, halted, wrote_register, written_index,
           written_value, divide_fault,
    input  ready
  );
  modport sink (
    input  valid, fetch_address, halted, wrote_register, written_index,
           written_value, divide_fault,
    output ready
  );
endinterface

@@ rtl/register_vm_execute_unit.sv @@
// Register VM execute unit. Takes one fetched instruction per transfer on
// instr and returns one transfer on result: the next fetch address, the
// halted flag, the register write it made and a divide-by-zero flag. The
// program counter lives in register 0 and is bumped before the instruction
// executes. Registers 1..REG_COUNT-1 sit in a small RAM with one read port,
// so the two source operands are read one after the other. An ordinary
// instruction goes through accept, read first operand, read second
// operand, execute and write back. Multiply and divide add a wait in
// a shared 32-step shift-add / trial-subtract unit between execute and
// write back; a divide by zero skips that unit. Once halted, an
// instruction goes from accept straight to write back and changes nothing.
// A finished result sits in the output register while the next instruction
// is taken; write-back waits only if that register is still full.
`include "register_vm_execute_unit_assert.svh"

module register_vm_execute_unit #(
  parameter int REG_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst,
  rvm_instr_if.sink    instr,
  rvm_result_if.source result
);
  import rvm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RDA  = 6'b000010,
    S_RDB  = 6'b000100,
    S_EXEC = 6'b001000,
    S_ITER = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t state;

  // Captured instruction.
  cmd_t              cmd_q;
  logic [IDX_W-1:0]  ia_q;
  logic [IDX_W-1:0]  ib_q;
  logic [IDX_W-1:0]  ic_q;
  logic [IMM_W-1:0]  imm_q;

  // Architectural state.
  logic [DATA_W-1:0] pc;
  logic              halt_flag;

  // Operands and pending write-back.
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic              wb_wrote;
  logic [IDX_W-1:0]  wb_idx;
  logic [DATA_W-1:0] wb_val;
  logic              wb_fault;
  logic              wb_jump;
  logic              wb_halt;

  logic              out_valid;

  // Execute-stage decode.
  logic              ex_wrote;
  logic [IDX_W-1:0]  ex_idx;
  logic [DATA_W-1:0] ex_val;
  logic              ex_fault;
  logic              ex_jump;
  logic              ex_halt;
  logic              ex_iter;
  logic              ex_sub;
  logic [DATA_W-1:0] ex_y;
  logic [DATA_W-1:0] ex_sum;

  // Write-back.
  logic              out_free;
  logic              wb_in_range;
  logic              wrote_eff;
  logic [DATA_W-1:0] pc_new;

  // Register file and shared unit.
  logic [IDX_W-1:0]  rf_rd_idx;
  logic [DATA_W-1:0] rf_rd_data;
  rf_wr_t            rf_wr;
  md_ctrl_t          md_ctrl;
  logic              md_done;
  logic [DATA_W-1:0] md_result;

  // Read the first operand index straight off the port at accept, the
  // second one the cycle after.
  assign rf_rd_idx = (state == S_IDLE) ? instr.reg_a : ib_q;

  rvm_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rf_rd_idx),
    .rd_data(rf_rd_data),
    .wr     (rf_wr),
    .wr_data(wb_val)
  );

  rvm_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (md_ctrl),
    .opa   (opa),
    .opb   (opb),
    .done  (md_done),
    .result(md_result)
  );

  // Inc, dec, add and sub share one adder: invert and carry in for subtract.
  assign ex_sub = (cmd_q == CMD_SUB) || (cmd_q == CMD_DEC);
  assign ex_y   = ((cmd_q == CMD_ADD) || (cmd_q == CMD_SUB)) ? opb : DATA_W'(1);
  assign ex_sum = opa + (ex_sub ? ~ex_y : ex_y) + DATA_W'(ex_sub);

  always_comb begin
    ex_wrote = 1'b0;
    ex_idx   = '0;
    ex_val   = '0;
    ex_fault = 1'b0;
    ex_jump  = 1'b0;
    ex_halt  = 1'b0;
    ex_iter  = 1'b0;
    unique case (cmd_q)
      CMD_HALT: ex_halt = 1'b1;
      CMD_LOAD: begin
        ex_wrote = 1'b1;
        ex_idx   = ia_q;
        ex_val   = {{(DATA_W-IMM_W){imm_q[IMM_W-1]}}, imm_q};
      end
      CMD_INC, CMD_DEC: begin
        ex_wrote = 1'b1;
        ex_idx   = ia_q;
        ex_val   = ex_sum;
      end
      CMD_ADD, CMD_SUB: begin
        ex_wrote = 1'b1;
        ex_idx   = ic_q;
        ex_val   = ex_sum;
      end
      CMD_MUL: begin
        ex_wrote = 1'b1;
        ex_idx   = ic_q;
        ex_iter  = 1'b1;
      end
      CMD_DIV: begin
        if (opb == '0) begin
          ex_fault = 1'b1;
        end else begin
          ex_wrote = 1'b1;
          ex_idx   = ic_q;
          ex_iter  = 1'b1;
        end
      end
      CMD_AND: begin
        ex_wrote = 1'b1;
        ex_idx   = ic_q;
        ex_val   = DATA_W'((opa != '0) && (opb != '0));
      end
      CMD_JUMP: ex_jump = 1'b1;
      CMD_JZ:   ex_jump = (opa == '0);
      default:  ex_jump = 1'b0;
    endcase
  end

  assign md_ctrl.start  = (state == S_EXEC) && ex_iter;
  assign md_ctrl.is_div = (cmd_q == CMD_DIV);

  // A write to an index past the file is dropped and not reported. A write
  // to register 0 replaces the program counter.
  assign out_free    = !out_valid || result.ready;
  assign wb_in_range = 32'(wb_idx) < 32'(REG_COUNT);
  assign wrote_eff   = wb_wrote && wb_in_range;
  assign pc_new      = (wrote_eff && (wb_idx == '0)) ? wb_val :
                       wb_jump ? {{(DATA_W-IMM_W){1'b0}}, imm_q} : pc;

  assign rf_wr.en  = (state == S_WB) && out_free && wrote_eff && (wb_idx != '0);
  assign rf_wr.idx = wb_idx;

  assign instr.ready  = (state == S_IDLE);
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      halt_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the held result once it transfers; write-back refills it itself.
      if (result.ready && (state != S_WB)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (instr.valid) begin
            cmd_q <= cmd_t'(instr.command);
            ia_q  <= instr.reg_a;
            ib_q  <= instr.reg_b;
            ic_q  <= instr.reg_c;
            imm_q <= instr.immediate;
            if (halt_flag) begin
              // Halted: report the unchanged state and nothing else.
              wb_wrote <= 1'b0;
              wb_idx   <= '0;
              wb_val   <= '0;
              wb_fault <= 1'b0;
              wb_jump  <= 1'b0;
              wb_halt  <= 1'b0;
              state    <= S_WB;
            end else begin
              pc    <= pc + DATA_W'(1);
              state <= S_RDA;
            end
          end
        end
        S_RDA: begin
          // Register 0 reads the already bumped program counter.
          opa   <= (ia_q == '0) ? pc : rf_rd_data;
          state <= S_RDB;
        end
        S_RDB: begin
          opb   <= (ib_q == '0) ? pc : rf_rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          wb_wrote <= ex_wrote;
          wb_idx   <= ex_idx;
          wb_val   <= ex_val;
          wb_fault <= ex_fault;
          wb_jump  <= ex_jump;
          wb_halt  <= ex_halt;
          state    <= ex_iter ? S_ITER : S_WB;
        end
        S_ITER: begin
          if (md_done) begin
            wb_val <= md_result;
            state  <= S_WB;
          end
        end
        S_WB: begin
          // Hold until the output register is free, then commit and report.
          if (out_free) begin
            pc                    <= pc_new;
            halt_flag             <= halt_flag | wb_halt;
            out_valid             <= 1'b1;
            result.fetch_address  <= pc_new;
            result.halted         <= halt_flag | wb_halt;
            result.wrote_register <= wrote_eff;
            result.written_index  <= wrote_eff ? wb_idx : '0;
            result.written_value  <= wrote_eff ? wb_val : '0;
            result.divide_fault   <= wb_fault;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RVM_ASSERT(a_halt_freezes_pc, halt_flag |=> $stable(pc), "pc moved after halt")
  `RVM_ASSERT(a_md_start_op, md_ctrl.start |-> cmd_q == CMD_MUL || cmd_q == CMD_DIV, "shared unit started for a simple op")
  `RVM_ASSERT(a_iter_op, state == S_ITER |-> cmd_q == CMD_MUL || cmd_q == CMD_DIV, "waiting on shared unit for a simple op")
  `RVM_ASSERT(a_fault_no_write, result.valid |-> !(result.wrote_register && result.divide_fault), "write reported with divide fault")

endmodule

@@ rtl/rvm_ram.sv @@
module rvm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rvm_regfile.sv @@
module rvm_regfile #(
  parameter int REG_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rvm_pkg::IDX_W-1:0]    rd_idx,
  output logic [rvm_pkg::DATA_W-1:0]   rd_data,
  input  rvm_pkg::rf_wr_t              wr,
  input  logic [rvm_pkg::DATA_W-1:0]   wr_data
);
  import rvm_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  logic [REG_COUNT-1:0] valid;
  logic                 rd_ok;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 rd_in_range;
  logic [DATA_W-1:0]    ram_q;

  assign rd_addr     = AW'(rd_idx);
  assign wr_addr     = AW'(wr.idx);
  assign rd_in_range = 32'(rd_idx) < 32'(REG_COUNT);

  rvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Entries never written read as zero; out-of-range indexes read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= rd_in_range && valid[rd_addr];
      if (wr.en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_ok ? ram_q : '0;

endmodule

@@ rtl/rvm_muldiv.sv @@
`include "register_vm_execute_unit_assert.svh"

module rvm_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  rvm_pkg::md_ctrl_t           ctrl,
  input  logic [rvm_pkg::DATA_W-1:0]  opa,
  input  logic [rvm_pkg::DATA_W-1:0]  opb,
  output logic                        done,
  output logic [rvm_pkg::DATA_W-1:0]  result
);
  import rvm_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic              fin;
  logic              is_div;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] acc;   // product, or remainder
  logic [DATA_W-1:0] mc;    // multiplicand, or divisor magnitude
  logic [DATA_W-1:0] q;     // multiplier, or dividend shifting into quotient

  logic [DATA_W-1:0] rem_sh;
  logic [DATA_W-1:0] add_x;
  logic [DATA_W-1:0] add_y;
  logic [DATA_W:0]   sum;

  // One shared adder: shift-add for multiply, trial subtract for divide.
  assign rem_sh = {acc[DATA_W-2:0], q[DATA_W-1]};
  assign add_x  = is_div ? rem_sh : acc;
  assign add_y  = is_div ? ~mc : mc;
  assign sum    = {1'b0, add_x} + {1'b0, add_y} + (DATA_W+1)'(is_div);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (ctrl.start) begin
        busy   <= 1'b1;
        is_div <= ctrl.is_div;
        cnt    <= '0;
        acc    <= '0;
        if (ctrl.is_div) begin
          mc  <= opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
          q   <= opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
          neg <= opa[DATA_W-1] ^ opb[DATA_W-1];
        end else begin
          mc  <= opa;
          q   <= opb;
          neg <= 1'b0;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (is_div) begin
          acc <= sum[DATA_W] ? sum[DATA_W-1:0] : rem_sh;
          q   <= {q[DATA_W-2:0], sum[DATA_W]};
        end else begin
          if (q[0]) begin
            acc <= sum[DATA_W-1:0];
          end
          mc <= {mc[DATA_W-2:0], 1'b0};
          q  <= {1'b0, q[DATA_W-1:1]};
        end
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign done   = fin;
  assign result = is_div ? (neg ? (DATA_W'(0) - q) : q) : acc;

  `RVM_ASSERT(a_start_when_free, ctrl.start |-> !busy && !fin, "start while unit busy")
  `RVM_ASSERT(a_done_pulse, fin |=> !fin, "done held longer than one cycle")
  `RVM_ASSERT(a_last_step, busy && !ctrl.start && cnt == CNT_W'(DATA_W - 1) |=> fin && !busy, "last step did not finish")

endmodule
